// ===== rtl/plc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plc_pkg
// Shared constants and types for the positional list engine: list capacity,
// derived widths, item kind codes, status codes and the cell operation code.
// ----------------------------------------------------------------------------
package plc_pkg;

    // Number of list slots, one cell each. Valid range 2 to 64.
    localparam int CAPACITY = 32;

    // Width that holds a length from 0 to CAPACITY.
    localparam int LEN_W = $clog2(CAPACITY + 1);
    // Width that indexes one slot (rotation step counter).
    localparam int CNT_W = $clog2(CAPACITY);

    localparam int KIND_W   = 2;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int OLEN_W   = 7;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // What a cell loads at the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_LOAD
    } t_cell_op;

endpackage

`default_nettype wire

// ===== rtl/positional_list_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit values kept in a chain of cells, with
// positional insert, positional delete and whole-list read-out.
// ----------------------------------------------------------------------------
// Insert and delete items: every cell at or beyond the position takes its
// neighbor's value in a single shift, and one result item with the status
// is written to the output register. A read-out item rotates the whole
// chain toward cell 0 once per cycle, except while a step that emits waits
// on a stalled output, through one full turn, so the list comes back to its
// original order at the end; the value in cell 0 is emitted during the
// first length steps. A read-out therefore holds the input until the full
// turn is done, stalls of the output included. An empty read-out, and every
// other item, give a single result. The output register lets a new item be
// taken while the previous result is being handed over, so single-result
// items can follow one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module positional_list_engine_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input channel.
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic        [plc_pkg::KIND_W-1:0]   i_kind,
    input  wire logic        [plc_pkg::POS_W-1:0]    i_position,
    input  wire logic signed [plc_pkg::VAL_W-1:0]    i_value,
    // Output channel.
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic             [plc_pkg::STATUS_W-1:0] o_status,
    output logic signed      [plc_pkg::VAL_W-1:0]    o_read_value,
    output logic                                     o_last,
    output logic             [plc_pkg::OLEN_W-1:0]   o_length
);
    import plc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state, n_state;
    logic [LEN_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Output register.
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status,    n_status;
    logic [VAL_W-1:0]    r_rd_value,  n_rd_value;
    logic                r_last,      n_last;

    logic [VAL_W-1:0] w_cell_q [CAPACITY];
    t_cell_op         w_op     [CAPACITY];

    logic             w_out_free;
    logic             w_accept;
    logic             w_emit;
    logic             w_step;
    logic [POS_W-1:0] w_pos_m1;
    logic [POS_W-1:0] w_len7;
    logic             w_ins_shift;
    logic             w_del_shift;

    // The chain. Cell 0 wraps to the last cell so a read-out can rotate.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        plc_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op[g]),
            .i_left  (w_cell_q[(g + CAPACITY - 1) % CAPACITY]),
            .i_right (w_cell_q[(g + 1) % CAPACITY]),
            .i_load  (i_value),
            .o_value (w_cell_q[g])
        );
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_pos_m1   = i_position - POS_W'(1);
    assign w_len7     = POS_W'(r_len);

    // During a read-out, the first length rotation steps each emit the value
    // in cell 0; the remaining steps only rotate and never wait on the output.
    assign w_emit = (r_state == S_READ) && (LEN_W'(r_cnt) < r_len);
    assign w_step = (r_state == S_READ) && (!w_emit || w_out_free);

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_rd_value  = r_rd_value;
        n_last      = r_last;
        w_ins_shift = 1'b0;
        w_del_shift = 1'b0;

        if (w_accept) begin
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_rd_value  = '0;
            n_last      = 1'b1;
            case (i_kind)
                KIND_INSERT: begin
                    if (r_len >= LEN_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else if (i_position == '0 || i_position > w_len7 + POS_W'(1)) begin
                        n_status = ST_BADPOS;
                    end else begin
                        w_ins_shift = 1'b1;
                        n_len       = r_len + LEN_W'(1);
                    end
                end
                KIND_DELETE: begin
                    if (r_len == '0) begin
                        n_status = ST_EMPTY;
                    end else if (i_position == '0 || i_position > w_len7) begin
                        n_status = ST_BADPOS;
                    end else begin
                        w_del_shift = 1'b1;
                        n_len       = r_len - LEN_W'(1);
                    end
                end
                KIND_READ: begin
                    if (r_len == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        // Results come out of the rotation, not from here.
                        n_out_valid = 1'b0;
                        n_state     = S_READ;
                        n_cnt       = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (w_step) begin
            if (w_emit) begin
                n_out_valid = 1'b1;
                n_status    = ST_OK;
                n_rd_value  = w_cell_q[0];
                n_last      = (LEN_W'(r_cnt) + LEN_W'(1)) == r_len;
            end
            if (r_cnt == CNT_W'(CAPACITY - 1)) begin
                n_state = S_IDLE;
            end
            n_cnt = r_cnt + CNT_W'(1);
        end

        for (int i = 0; i < CAPACITY; i++) begin
            w_op[i] = CELL_HOLD;
            if (w_step) begin
                w_op[i] = CELL_RIGHT;
            end else if (w_ins_shift) begin
                if (POS_W'(i) == w_pos_m1) begin
                    w_op[i] = CELL_LOAD;
                end else if (POS_W'(i) > w_pos_m1) begin
                    w_op[i] = CELL_LEFT;
                end
            end else if (w_del_shift) begin
                if (POS_W'(i) >= w_pos_m1) begin
                    w_op[i] = CELL_RIGHT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_status   <= n_status;
        r_rd_value <= n_rd_value;
        r_last     <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_rd_value;
    assign o_last       = r_last;
    assign o_length     = OLEN_W'(r_len);

    // The stored length never exceeds the number of cells.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    // No new item is taken while a read-out is rotating the chain.
    a_read_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> o_in_stall)
        else $error("input accepted during read-out");

    // A read-out never changes the length.
    a_read_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> $stable(r_len))
        else $error("length changed during read-out");

    // The final rotation step returns the engine to idle.
    a_read_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_cnt == CNT_W'(CAPACITY - 1)) |=> (r_state == S_IDLE))
        else $error("read-out did not finish after a full rotation");

endmodule

`default_nettype wire

// ===== rtl/plc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plc_cell
// One list slot. Holds a value, or takes its left neighbor, its right
// neighbor or a new value, as the operation code says.
// ----------------------------------------------------------------------------
module plc_cell (
    input  wire logic                      i_clk,
    input  wire plc_pkg::t_cell_op         i_op,
    input  wire logic [plc_pkg::VAL_W-1:0] i_left,
    input  wire logic [plc_pkg::VAL_W-1:0] i_right,
    input  wire logic [plc_pkg::VAL_W-1:0] i_load,
    output logic      [plc_pkg::VAL_W-1:0] o_value
);
    import plc_pkg::*;

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;

    always_comb begin
        case (i_op)
            CELL_LEFT:  n_value = i_left;
            CELL_RIGHT: n_value = i_right;
            CELL_LOAD:  n_value = i_load;
            default:    n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire
